[rtl/core/crfr_pkg.sv]
`default_nettype none

package crfr_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 32;

    localparam logic [7:0] SYNC_BYTE_RESET  = 8'hC8;
    localparam logic [7:0] FRAME_TYPE_RESET = 8'h16;

    localparam int CHANNEL_FRAME_LEN = 24;
    localparam int CHANNEL_COUNT     = 16;
    localparam int CHANNEL_BITS      = 11;
    localparam int CHANNEL_BYTES     = 22;
    localparam int CHANNEL_IDX_W     = 4;

    // bit accumulator: up to ten leftover bits plus one fresh byte
    localparam int ACC_W      = CHANNEL_BITS + 7;
    localparam int NBITS_W    = 5;
    localparam int BYTE_IDX_W = 5;

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TYPE = 4'd1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_PAYLOAD
    } front_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_CHECK
    } back_state_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    typedef struct packed {
        logic [CHANNEL_IDX_W-1:0] index;
        logic [CHANNEL_BITS-1:0]  value;
        logic                     last;
    } chan_item_t;

endpackage

`default_nettype wire

[rtl/core/crfr_fifo.sv]
`default_nettype none

module crfr_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/crfr_front.sv]
`default_nettype none

module crfr_front
    import crfr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1),
    localparam int MEM_AW = $clog2(2 * BUFFER_BYTES)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   push,
    input  wire logic [7:0]             rx_byte,
    output logic                        full,
    output logic                        mem_we,
    output logic [MEM_AW-1:0]           mem_addr,
    output logic [7:0]                  mem_data,
    output logic                        job_push,
    output logic                        job_bank,
    input  wire bank_release_t          release_in
);

    front_phase_t     phase_reg, phase_next;
    logic [7:0]       sync_reg;
    logic [7:0]       type_reg;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_inc;
    logic [7:0]       first_reg;
    logic             bank_reg;
    logic [1:0]       busy_reg, busy_next;
    logic             accept;
    logic             length_bad;
    logic             last_byte;
    logic             frame_good;

    // hold input while the bank being filled still waits for the unpacker
    assign full       = busy_reg[bank_reg];
    assign accept     = push && !full;
    assign length_bad = (rx_byte == 8'd0) || ({1'b0, rx_byte} > 9'(BUFFER_BYTES));
    assign pos_inc    = pos_reg + 1'b1;
    assign last_byte  = (pos_inc == length_reg);
    assign frame_good = (length_reg == LEN_W'(CHANNEL_FRAME_LEN)) && (first_reg == type_reg);
    assign mem_addr   = (bank_reg ? MEM_AW'(BUFFER_BYTES) : '0) + MEM_AW'(pos_reg);
    assign mem_data   = rx_byte;
    assign job_bank   = bank_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (accept && (rx_byte == sync_reg))
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (accept)
                begin
                    phase_next = length_bad ? PH_HUNT : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (accept && last_byte)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        mem_we   = 1'b0;
        job_push = 1'b0;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                mem_we   = accept;
                job_push = accept && last_byte && frame_good;
            end
            default:
            begin
                mem_we   = 1'b0;
                job_push = 1'b0;
            end
        endcase
    end

    // a finished bank goes to the unpacker, which frees that bank once unpacked
    always_comb
    begin
        busy_next = busy_reg;
        if (job_push)
        begin
            busy_next[bank_reg] = 1'b1;
        end
        if (release_in.valid)
        begin
            busy_next[release_in.bank] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            sync_reg   <= SYNC_BYTE_RESET;
            type_reg   <= FRAME_TYPE_RESET;
            length_reg <= '0;
            pos_reg    <= '0;
            bank_reg   <= 1'b0;
            busy_reg   <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            if (cfg_we && (cfg_index == CFG_SYNC_BYTE))
            begin
                sync_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_FRAME_TYPE))
            begin
                type_reg <= cfg_data;
            end
            if ((phase_reg == PH_LENGTH) && accept && !length_bad)
            begin
                length_reg <= rx_byte[LEN_W-1:0];
                pos_reg    <= '0;
            end
            if (mem_we)
            begin
                pos_reg <= pos_inc;
            end
            // advance to the other bank once a frame is handed off
            if (job_push)
            begin
                bank_reg <= !bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && (pos_reg == '0))
        begin
            first_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/core/crfr_back.sv]
`default_nettype none

module crfr_back
    import crfr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
    localparam int MEM_AW = $clog2(2 * BUFFER_BYTES)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              mem_we,
    input  wire logic [MEM_AW-1:0] mem_addr,
    input  wire logic [7:0]        mem_data,
    input  wire logic              job_empty,
    input  wire logic              job_bank,
    output logic                   job_pop,
    input  wire logic              out_full,
    output logic                   out_push,
    output chan_item_t             out_item,
    output bank_release_t          release_out
);

    localparam int MEM_DEPTH = 2 * BUFFER_BYTES;

    logic [7:0]               payload_mem [MEM_DEPTH];
    logic [7:0]               rdata_reg;
    back_state_t              state_reg, state_next;
    logic                     bank_reg;
    logic [BYTE_IDX_W-1:0]    byte_idx_reg;
    logic [NBITS_W-1:0]       nbits_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [CHANNEL_IDX_W-1:0] ch_reg;
    logic                     rd_en;
    logic [MEM_AW-1:0]        rd_addr;
    logic                     have_channel;
    logic                     last_ch;

    assign rd_addr      = (bank_reg ? MEM_AW'(BUFFER_BYTES) : '0) + MEM_AW'(byte_idx_reg);
    assign have_channel = (nbits_reg >= NBITS_W'(CHANNEL_BITS));
    assign last_ch      = (ch_reg == CHANNEL_IDX_W'(CHANNEL_COUNT - 1));

    assign out_item.index = ch_reg;
    assign out_item.value = acc_reg[CHANNEL_BITS-1:0];
    assign out_item.last  = last_ch;
    assign release_out.bank = bank_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (!have_channel)
                begin
                    state_next = BK_READ;
                end
                else if (!out_full && last_ch)
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        job_pop           = 1'b0;
        rd_en             = 1'b0;
        out_push          = 1'b0;
        release_out.valid = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                job_pop = !job_empty;
            end
            BK_READ:
            begin
                rd_en = 1'b1;
            end
            BK_LOAD:
            begin
                rd_en = 1'b0;
            end
            BK_CHECK:
            begin
                out_push          = have_channel && !out_full;
                release_out.valid = have_channel && !out_full && last_ch;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            bank_reg     <= 1'b0;
            byte_idx_reg <= '0;
            nbits_reg    <= '0;
            acc_reg      <= '0;
            ch_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
            begin
                // skip the type byte: channel bits start at payload byte one
                bank_reg     <= job_bank;
                byte_idx_reg <= BYTE_IDX_W'(1);
                nbits_reg    <= '0;
                acc_reg      <= '0;
                ch_reg       <= '0;
            end
            if (state_reg == BK_LOAD)
            begin
                acc_reg      <= acc_reg | (ACC_W'(rdata_reg) << nbits_reg);
                nbits_reg    <= nbits_reg + NBITS_W'(8);
                byte_idx_reg <= byte_idx_reg + 1'b1;
            end
            if (out_push)
            begin
                acc_reg   <= acc_reg >> CHANNEL_BITS;
                nbits_reg <= nbits_reg - NBITS_W'(CHANNEL_BITS);
                ch_reg    <= ch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[mem_addr] <= mem_data;
        end
        if (rd_en)
        begin
            rdata_reg <= payload_mem[rd_addr];
        end
    end

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOAD) |-> $past(state_reg == BK_READ))
        else $error("unpacker loaded without a preceding read");

    a_release_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        release_out.valid |=> (state_reg == BK_IDLE))
        else $error("unpacker kept running after releasing its bank");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CHECK) |-> (nbits_reg <= NBITS_W'(ACC_W)))
        else $error("bit accumulator overflow");

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> (byte_idx_reg <= BYTE_IDX_W'(CHANNEL_BYTES)))
        else $error("unpacker read past the channel bytes");

endmodule

`default_nettype wire

[rtl/core/rc_channel_frame_receiver_core.sv]
`default_nettype none

// Receives serial bytes and decodes RC channel frames (sync, length, payload).
// A byte transfers on every cycle with push high and full low; the parser
// takes one byte per cycle. Payloads are kept in two banks: full stays high
// while the bank being filled still holds a frame waiting to be unpacked.
// For a frame of length 24 whose type byte matches, sixteen 11-bit channel
// values come out of the result queue in order, last_channel marking channel
// 15; every other frame is dropped silently. The unpacker has a single
// payload-memory read port: it steps through read, load and check states for
// each of the 22 channel bytes and emits channels from the check state; a full
// result queue stalls it.
// Configuration writes take effect at once.

module rc_channel_frame_receiver_core
    import crfr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]               cfg_data,
    input  wire logic                     push,
    input  wire logic [7:0]               rx_byte,
    output logic                          full,
    input  wire logic                     pop,
    output logic                          empty,
    output logic [CHANNEL_IDX_W-1:0]      channel_index,
    output logic [CHANNEL_BITS-1:0]       channel_value,
    output logic                          last_channel
);

    localparam int MEM_AW = $clog2(2 * BUFFER_BYTES);

    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_data;
    logic              job_push;
    logic              job_bank_in;
    logic              job_full;
    logic              job_pop;
    logic              job_bank_out;
    logic              job_empty;
    logic              out_push;
    logic              out_full;
    chan_item_t        out_item;
    chan_item_t        head_item;
    bank_release_t     bank_release;

    crfr_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_data  (mem_data),
        .job_push  (job_push),
        .job_bank  (job_bank_in),
        .release_in(bank_release)
    );

    // at most two banks are outstanding, so this queue never overflows
    crfr_fifo #(
        .WIDTH(1),
        .DEPTH(2)
    ) u_job_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_data(job_bank_in),
        .full   (job_full),
        .pop    (job_pop),
        .rd_data(job_bank_out),
        .empty  (job_empty)
    );

    crfr_back #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_data   (mem_data),
        .job_empty  (job_empty),
        .job_bank   (job_bank_out),
        .job_pop    (job_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_item   (out_item),
        .release_out(bank_release)
    );

    crfr_fifo #(
        .WIDTH($bits(chan_item_t)),
        .DEPTH(2)
    ) u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (out_push),
        .wr_data(out_item),
        .full   (out_full),
        .pop    (pop),
        .rd_data(head_item),
        .empty  (empty)
    );

    assign channel_index = head_item.index;
    assign channel_value = head_item.value;
    assign last_channel  = head_item.last;

    a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("frame job queue overflow");

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crfr_pkg::*;

    localparam int PAYLOAD_MAX = BUFFER_BYTES_DEFAULT;
    // time for the unpacker to finish after the queues drain; leave margin for dropped frames
    localparam int SETTLE_CYCLES = 150;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_LAST = '1;
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS = 1;
    localparam int FILL_ONES = 2;

    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } rx_item_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [7:0]                cfg_data = '0;
    logic                      push = 1'b0;
    logic [7:0]                rx_byte = '0;
    logic                      pop = 1'b0;
    logic                      full;
    logic                      empty;
    logic [CHANNEL_IDX_W-1:0]  channel_index;
    logic [CHANNEL_BITS-1:0]   channel_value;
    logic                      last_channel;

    // frame parser mirror
    logic [7:0]   sync_cfg = SYNC_BYTE_RESET;
    logic [7:0]   type_cfg = FRAME_TYPE_RESET;
    front_phase_t parse_state = PH_HUNT;
    int unsigned  frame_len = 0;
    int unsigned  frame_pos = 0;
    logic [7:0]   frame_bytes [PAYLOAD_MAX];

    chan_item_t      expected_channels [$];
    rx_item_t        rx_items [$];
    int unsigned     queued_bytes = 0;
    int unsigned     mismatches = 0;
    longint unsigned cycle_count = 0;

    int unsigned send_gap = 0;
    bit          send_burst = 1'b0;
    int unsigned pop_hold = 0;
    bit          take_burst = 1'b0;

    rc_channel_frame_receiver_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .rx_byte       (rx_byte),
        .full          (full),
        .pop           (pop),
        .empty         (empty),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    function automatic void unpack_channels();
        logic [CHANNEL_BYTES*8-1:0] payload_bits;
        chan_item_t ch;
        for (int i = 0; i < CHANNEL_BYTES; i++)
        begin
            payload_bits[i*8 +: 8] = frame_bytes[i + 1];
        end
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            ch.index = c[CHANNEL_IDX_W-1:0];
            ch.value = payload_bits[c*CHANNEL_BITS +: CHANNEL_BITS];
            ch.last  = (c == CHANNEL_COUNT - 1);
            expected_channels.push_back(ch);
        end
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        case (parse_state)
            PH_HUNT:
            begin
                if (b == sync_cfg)
                    parse_state = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                // zero and over-long lengths drop the frame
                if (b == 0 || b > PAYLOAD_MAX)
                    parse_state = PH_HUNT;
                else
                begin
                    frame_len = b;
                    frame_pos = 0;
                    parse_state = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                frame_bytes[frame_pos] = b;
                frame_pos++;
                if (frame_pos >= frame_len)
                begin
                    parse_state = PH_HUNT;
                    if (frame_len == CHANNEL_FRAME_LEN && frame_bytes[0] == type_cfg)
                        unpack_channels();
                end
            end
            default:
                parse_state = PH_HUNT;
        endcase
    endfunction

    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_byte(logic [7:0] data, bit drain_first = 1'b0);
        rx_item_t it;
        it.data = data;
        it.drain_first = drain_first;
        rx_items.push_back(it);
        queued_bytes++;
    endfunction

    // sync, length, then payload_count bytes: the type byte and fill after it
    function automatic void queue_frame(logic [7:0] len_byte, logic [7:0] kind,
                                        int unsigned payload_count, int fill,
                                        bit drain_first = 1'b0);
        queue_byte(sync_cfg, drain_first);
        queue_byte(len_byte);
        if (payload_count > 0)
            queue_byte(kind);
        for (int i = 1; i < payload_count; i++)
        begin
            case (fill)
                FILL_ZEROS: queue_byte(8'h00);
                FILL_ONES:  queue_byte(8'hFF);
                default:    queue_byte(8'($urandom));
            endcase
        end
    endfunction

    function automatic void queue_special_cases();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h55);
        queue_byte(8'hAA);
        queue_frame(8'd0, 8'h00, 0, FILL_RANDOM);
        queue_frame(8'(PAYLOAD_MAX + 1), 8'h00, 0, FILL_RANDOM);
        queue_frame(8'hFF, 8'h00, 0, FILL_RANDOM);
        queue_frame(sync_cfg, 8'h00, 0, FILL_RANDOM);
        queue_frame(8'd1, type_cfg, 1, FILL_RANDOM);
        queue_frame(8'd2, sync_cfg, 1, FILL_RANDOM);
        queue_byte(sync_cfg);
    endfunction

    function automatic void queue_traffic(int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        int          fill;
        bit          drain;
        stop_at = queued_bytes + budget;
        queue_frame(8'(CHANNEL_FRAME_LEN), type_cfg, CHANNEL_FRAME_LEN, FILL_ONES);
        // hold off until the all-ones frame has fully drained
        queue_frame(8'(CHANNEL_FRAME_LEN), type_cfg, CHANNEL_FRAME_LEN, FILL_ZEROS, 1'b1);
        while (queued_bytes < stop_at)
        begin
            pick = $urandom_range(0, 99);
            fill = ($urandom_range(0, 9) < 8) ? FILL_RANDOM : $urandom_range(FILL_ZEROS, FILL_ONES);
            drain = ($urandom_range(0, 29) == 0);
            if (pick < 65)
                queue_frame(8'(CHANNEL_FRAME_LEN), type_cfg, CHANNEL_FRAME_LEN, fill, drain);
            else if (pick < 72)
                queue_frame(8'(CHANNEL_FRAME_LEN), type_cfg ^ (8'h01 << $urandom_range(0, 7)),
                            CHANNEL_FRAME_LEN, fill, drain);
            else if (pick < 80)
            begin
                len = $urandom_range(1, PAYLOAD_MAX);
                queue_frame(8'(len), $urandom_range(0, 1) ? type_cfg : 8'($urandom),
                            len, fill, drain);
            end
            else if (pick < 85)
                // cut short: following bytes land in this payload
                queue_frame(8'(CHANNEL_FRAME_LEN), type_cfg,
                            $urandom_range(0, CHANNEL_FRAME_LEN - 1), fill, drain);
            else if (pick < 90)
            begin
                queue_byte(sync_cfg, drain);
                queue_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(PAYLOAD_MAX + 1, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom), drain);
            end
        end
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_SYNC_BYTE)
            sync_cfg = val;
        else if (idx == CFG_FRAME_TYPE)
            type_cfg = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (rx_items.size() != 0 || push || expected_channels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_bytes
        rx_item_t nxt;
        // predict the byte taken at this edge before deciding on a drain pause
        if (push && !full)
            parse_rx_byte(rx_byte);
        if (rst_n && (!push || !full))
        begin
            if (send_gap != 0)
            begin
                push <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (rx_items.size() == 0 ||
                     (rx_items[0].drain_first && expected_channels.size() != 0))
                push <= 1'b0;
            else
            begin
                nxt = rx_items.pop_front();
                push <= 1'b1;
                rx_byte <= nxt.data;
                send_gap <= pick_gap(send_burst);
                if ($urandom_range(0, 39) == 0)
                    send_burst <= !send_burst;
            end
        end
    end

    always @(posedge clk)
    begin : watch_channels
        chan_item_t  want;
        int unsigned hold;
        hold = pop_hold;
        if (pop && !empty)
        begin
            hold = pick_gap(take_burst);
            if ($urandom_range(0, 39) == 0)
                take_burst <= !take_burst;
            if (expected_channels.size() == 0)
            begin
                $error("unexpected channel transfer: index %0d value %0d",
                       channel_index, channel_value);
                mismatches++;
            end
            else
            begin
                want = expected_channels.pop_front();
                if (channel_index !== want.index)
                begin
                    $error("channel_index: expected %0d, actual %0d", want.index, channel_index);
                    mismatches++;
                end
                if (channel_value !== want.value)
                begin
                    $error("channel_value: expected %0d, actual %0d", want.value, channel_value);
                    mismatches++;
                end
                if (last_channel !== want.last)
                begin
                    $error("last_channel: expected %0d, actual %0d", want.last, last_channel);
                    mismatches++;
                end
            end
        end
        if (rst_n)
        begin
            if (hold != 0)
            begin
                pop <= 1'b0;
                pop_hold <= hold - 1;
            end
            else
            begin
                pop <= 1'b1;
                pop_hold <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_special_cases();
        queue_traffic(70);
        wait_drained();

        write_reg(CFG_SYNC_BYTE, 8'h00);
        write_reg(CFG_FRAME_TYPE, 8'h00);
        write_reg(CFG_INDEX_LAST, 8'($urandom));
        queue_traffic(70);
        wait_drained();

        write_reg(CFG_SYNC_BYTE, 8'hFF);
        write_reg(CFG_FRAME_TYPE, 8'hFF);
        queue_traffic(70);
        wait_drained();

        write_reg(CFG_SYNC_BYTE, 8'($urandom));
        write_reg(CFG_FRAME_TYPE, 8'($urandom));
        write_reg(CFG_INDEX_W'($urandom_range(CFG_FRAME_TYPE + 1, CFG_INDEX_LAST)),
                  8'($urandom));
        queue_traffic(70);
        wait_drained();

        write_reg(CFG_SYNC_BYTE, SYNC_BYTE_RESET);
        write_reg(CFG_FRAME_TYPE, FRAME_TYPE_RESET);
        queue_traffic(70);
        wait_drained();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
